@@ rtl/rrg_pkg.sv @@
// ----------------------------------------------------------------------------
// Refracted ray generate: shared constants, types and step functions
// Fixed-point formats, iteration counts and the single-step helpers
// used by the square-root and division pipelines.
// ----------------------------------------------------------------------------
package rrg_pkg;

	localparam int unsigned DIR_WIDTH_DEF = 16;
	localparam int unsigned IQ_FRAC       = 24;
	localparam int unsigned HIT_W         = 32;
	localparam int unsigned OFFSET_W      = 16;
	localparam int unsigned INDEX_W       = 15;

	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd655;
	localparam logic [INDEX_W-1:0]  MIN_INDEX    = 15'd1024;

	// eta = round(2^36 / r): long division, quotient below 2^27
	localparam int unsigned ETA_W       = 27;
	localparam int unsigned ETA_ITERS   = 27;
	localparam int unsigned ETA_REM_W   = 16;
	localparam int unsigned ETA_STEPS   = 7;
	localparam int unsigned ETA_STAGES  = (ETA_ITERS + ETA_STEPS - 1) / ETA_STEPS;
	localparam logic [ETA_REM_W-1:0] ETA_REM_INIT = 16'd512;

	// digit-by-digit square root of a 64-bit radicand
	localparam int unsigned SQ_IN_W    = 64;
	localparam int unsigned SQ_ROOT_W  = 32;
	localparam int unsigned SQ_REM_W   = 36;
	localparam int unsigned SQ_ITERS   = 32;
	localparam int unsigned SQ_STEPS   = 2;
	localparam int unsigned SQ_STAGES  = SQ_ITERS / SQ_STEPS;

	// normalising division by the vector length
	localparam int unsigned LEN_W      = 32;
	localparam int unsigned NRM_REM_W  = 33;
	localparam int unsigned NRM_STEPS  = 2;

	typedef struct packed {
		logic [ETA_REM_W-1:0] rem;
		logic [ETA_W-1:0]     lo;
		logic [ETA_W-1:0]     q;
	} eta_div_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0]  rem;
		logic [SQ_ROOT_W-1:0] root;
		logic [SQ_IN_W-1:0]   x;
	} sqrt_state_t;

	typedef struct packed {
		logic [NRM_REM_W-1:0] rem;
		logic [LEN_W-1:0]     lo;
		logic [LEN_W-1:0]     q;
	} nrm_div_t;

	// one restoring step, divisor below 2^15
	function automatic eta_div_t eta_step(eta_div_t s, logic [INDEX_W-1:0] den);
		logic [ETA_REM_W-1:0] acc;
		eta_div_t o;
		acc  = {s.rem[ETA_REM_W-2:0], s.lo[ETA_W-1]};
		o.lo = {s.lo[ETA_W-2:0], 1'b0};
		if (acc >= {1'b0, den}) begin
			o.rem = acc - {1'b0, den};
			o.q   = {s.q[ETA_W-2:0], 1'b1};
		end else begin
			o.rem = acc;
			o.q   = {s.q[ETA_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// one root digit: bring down two radicand bits, trial subtract
	function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
		logic [SQ_REM_W-1:0] acc;
		logic [SQ_REM_W-1:0] trial;
		sqrt_state_t o;
		acc   = {s.rem[SQ_REM_W-3:0], s.x[SQ_IN_W-1 -: 2]};
		trial = SQ_REM_W'({s.root, 2'b01});
		o.x   = {s.x[SQ_IN_W-3:0], 2'b00};
		if (acc >= trial) begin
			o.rem  = acc - trial;
			o.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = acc;
			o.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// one restoring step, divisor up to 32 bits
	function automatic nrm_div_t nrm_step(nrm_div_t s, logic [LEN_W-1:0] den);
		logic [NRM_REM_W-1:0] acc;
		nrm_div_t o;
		acc  = {s.rem[NRM_REM_W-2:0], s.lo[LEN_W-1]};
		o.lo = {s.lo[LEN_W-2:0], 1'b0};
		if (acc >= {1'b0, den}) begin
			o.rem = acc - {1'b0, den};
			o.q   = {s.q[LEN_W-2:0], 1'b1};
		end else begin
			o.rem = acc;
			o.q   = {s.q[LEN_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

@@ rtl/refracted_ray_generate_unit.sv @@
// ----------------------------------------------------------------------------
// Refracted ray generate unit
// Snell refraction of a unit direction at a surface hit, fixed point.
// ----------------------------------------------------------------------------
// Usage
//   Input: present a transaction on the hit, normal, incoming and index ports
//   with start high; it is taken at a clock edge where busy is low. busy is
//   held low, so one transaction may enter on every clock cycle.
//   Output: each result sits on refracted, origin_* and out_dir_* for exactly
//   one cycle, flagged by done. The receiver has no way to stall the block
//   and must take each result in the cycle it is shown.
//   Configuration: cfg_wr_en writes surface_offset (Q0.16) at the clock edge;
//   change it only while no transaction is in flight.
// Timing
//   The two 32-digit square-root pipelines, two digits per stage, make up most
//   of the pipeline depth. Throughput is one transaction per cycle.
// Reset
//   arst_n clears every valid bit, drops done and restores surface_offset
//   to 655 (0.01). Data registers are not reset.
// ----------------------------------------------------------------------------
module refracted_ray_generate_unit #(
	parameter int unsigned DIR_WIDTH = rrg_pkg::DIR_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	output logic                                done,
	input  logic                                cfg_wr_en,
	input  logic [rrg_pkg::OFFSET_W-1:0]        cfg_wr_data,
	input  logic signed [rrg_pkg::HIT_W-1:0]    hit_x,
	input  logic signed [rrg_pkg::HIT_W-1:0]    hit_y,
	input  logic signed [rrg_pkg::HIT_W-1:0]    hit_z,
	input  logic signed [DIR_WIDTH-1:0]         normal_x,
	input  logic signed [DIR_WIDTH-1:0]         normal_y,
	input  logic signed [DIR_WIDTH-1:0]         normal_z,
	input  logic signed [DIR_WIDTH-1:0]         incoming_x,
	input  logic signed [DIR_WIDTH-1:0]         incoming_y,
	input  logic signed [DIR_WIDTH-1:0]         incoming_z,
	input  logic [rrg_pkg::INDEX_W-1:0]         refractive_index,
	output logic                                refracted,
	output logic signed [rrg_pkg::HIT_W-1:0]    origin_x,
	output logic signed [rrg_pkg::HIT_W-1:0]    origin_y,
	output logic signed [rrg_pkg::HIT_W-1:0]    origin_z,
	output logic signed [DIR_WIDTH-1:0]         out_dir_x,
	output logic signed [DIR_WIDTH-1:0]         out_dir_y,
	output logic signed [DIR_WIDTH-1:0]         out_dir_z
);
	import rrg_pkg::*;

	// direction fraction bits and the shifts that bring values to 24 fraction bits
	localparam int unsigned F        = DIR_WIDTH - 2;
	localparam int unsigned PW       = 2 * DIR_WIDTH;
	localparam int unsigned DOT_SHR  = (2 * F >= IQ_FRAC) ? 2 * F - IQ_FRAC : 0;
	localparam int unsigned DOT_SHL  = (2 * F < IQ_FRAC) ? IQ_FRAC - 2 * F : 0;
	localparam int unsigned PQW      = PW + DOT_SHL;
	localparam int unsigned DQ_SHR   = (F > IQ_FRAC) ? F - IQ_FRAC : 0;
	localparam int unsigned DQ_SHL   = (F < IQ_FRAC) ? IQ_FRAC - F : 0;
	localparam int unsigned DQE      = DIR_WIDTH + 1 + DQ_SHL;
	localparam logic [PW-1:0] DOT_MASK = PW'((64'd1 << DOT_SHR) - 64'd1);

	// internal value widths
	localparam int unsigned C_W      = 30;
	localparam int unsigned C2_W     = 33;
	localparam int unsigned ETA2_W   = 31;
	localparam int unsigned ETAC_W   = 32;
	localparam int unsigned S_W      = 40;
	localparam int unsigned COEF_W   = 34;
	localparam int unsigned Q_W      = 27;
	localparam int unsigned ED_W     = 30;
	localparam int unsigned CN_W     = 36;
	localparam int unsigned TD_W     = 37;
	localparam int unsigned T_W      = 32;
	localparam int unsigned TSQ_W    = 61;
	localparam int unsigned MAG_W    = 31;
	localparam int unsigned NUM_W    = F + 33;
	localparam int unsigned PROD_W   = DIR_WIDTH + OFFSET_W + 1;
	localparam int unsigned OFF_W    = 19;
	localparam int unsigned SUM_W    = HIT_W + 2;

	localparam logic signed [33:0]     ONE_OMC  = 34'sd16777216;
	localparam logic signed [S_W-1:0]  ONE_S    = 40'sd16777216;
	localparam logic signed [TD_W-1:0] T_MAX    = 37'sd1073741824;
	localparam logic signed [TD_W-1:0] T_MIN    = -37'sd1073741824;
	localparam logic signed [SUM_W-1:0] HIT_MAX = 34'sd2147483647;
	localparam logic signed [SUM_W-1:0] HIT_MIN = -34'sd2147483648;
	localparam logic signed [PROD_W:0] RND      = (PROD_W + 1)'(64'd1 << (F - 1));

	localparam int unsigned NRM_ITERS  = F + 1;
	localparam int unsigned NRM_STAGES = (NRM_ITERS + NRM_STEPS - 1) / NRM_STEPS;

	// stage map: index of the register each stage loads
	localparam int unsigned ST_IN   = 1;
	localparam int unsigned ST_MUL  = 2;
	localparam int unsigned ST_DOT  = 3;
	localparam int unsigned ST_ETA0 = 4;
	localparam int unsigned ST_E1   = ST_ETA0 + ETA_STAGES;
	localparam int unsigned ST_E2   = ST_E1 + 1;
	localparam int unsigned ST_E3   = ST_E2 + 1;
	localparam int unsigned ST_Q1   = ST_E3 + 1;
	localparam int unsigned ST_F1   = ST_Q1 + SQ_STAGES;
	localparam int unsigned ST_F2   = ST_F1 + 1;
	localparam int unsigned ST_F3   = ST_F2 + 1;
	localparam int unsigned ST_F4   = ST_F3 + 1;
	localparam int unsigned ST_F5   = ST_F4 + 1;
	localparam int unsigned ST_Q2   = ST_F5 + 1;
	localparam int unsigned ST_N0   = ST_Q2 + SQ_STAGES;
	localparam int unsigned ST_N1   = ST_N0 + 1;
	localparam int unsigned ST_G1   = ST_N1 + NRM_STAGES;
	localparam int unsigned ST_G2   = ST_G1 + 1;
	localparam int unsigned ST_LAST = ST_G2;

	// everything a transaction carries down the pipe; bits a stage never
	// reads again are left for synthesis to strip
	typedef struct packed {
		logic [2:0][HIT_W-1:0]      hit;
		logic [2:0][DIR_WIDTH:0]    nv;
		logic [2:0][DIR_WIDTH-1:0]  dv;
		logic [INDEX_W-1:0]         r;
		logic [2:0][PW-1:0]         p;
		logic                       leave;
		logic [C_W-1:0]             c;
		eta_div_t                   eta_div;
		logic [ETA_W-1:0]           eta;
		logic [C2_W-1:0]            c2;
		logic [ETA2_W-1:0]          eta2;
		logic [ETAC_W-1:0]          etac;
		logic [S_W-1:0]             s;
		logic                       tir;
		sqrt_state_t                sq;
		logic [COEF_W-1:0]          coef;
		logic [2:0][ED_W-1:0]       ed;
		logic [2:0][CN_W-1:0]       cn;
		logic [2:0][T_W-1:0]        t;
		logic [2:0][TSQ_W-1:0]      tsq;
		logic [LEN_W-1:0]           len;
		nrm_div_t [2:0]             nd;
		logic [2:0]                 neg;
		logic [2:0][DIR_WIDTH-1:0]  dir;
		logic [2:0][PROD_W-1:0]     prod;
		logic [2:0][OFF_W-1:0]      off;
	} ctx_t;

	logic                  accept;
	logic [OFFSET_W-1:0]   surface_offset_q;
	logic                  vld_s  [1:ST_LAST];
	ctx_t                  pipe_s [1:ST_LAST];
	ctx_t                  nxt    [1:ST_LAST];

	logic                        done_q;
	logic                        refracted_q;
	logic [2:0][HIT_W-1:0]       origin_q;
	logic [2:0][DIR_WIDTH-1:0]   dir_q;

	// the pipe never stalls, so a transaction is taken in every cycle that start is high
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surface_offset_q <= OFFSET_RESET;
		end else if (cfg_wr_en) begin
			surface_offset_q <= cfg_wr_data;
		end
	end

	// per-stage combinational work
	for (genvar k = 1; k <= ST_LAST; k++) begin : g_stage
		ctx_t st;

		if (k == ST_IN) begin : g_in
			// capture the transaction, clamp the index to 0.25
			always_comb begin
				st        = '0;
				st.hit[0] = hit_x;
				st.hit[1] = hit_y;
				st.hit[2] = hit_z;
				st.nv[0]  = (DIR_WIDTH + 1)'(normal_x);
				st.nv[1]  = (DIR_WIDTH + 1)'(normal_y);
				st.nv[2]  = (DIR_WIDTH + 1)'(normal_z);
				st.dv[0]  = incoming_x;
				st.dv[1]  = incoming_y;
				st.dv[2]  = incoming_z;
				st.r      = (refractive_index < MIN_INDEX) ? MIN_INDEX : refractive_index;
			end
		end else if (k == ST_MUL) begin : g_mul
			always_comb begin
				st = pipe_s[k-1];
				for (int i = 0; i < 3; i++) begin
					st.p[i] = PW'($signed(st.nv[i][DIR_WIDTH-1:0]) * $signed(st.dv[i]));
				end
			end
		end else if (k == ST_DOT) begin : g_dot
			// dot product both ways round: the flipped normal floors -p
			always_comb begin
				logic signed [PQW-1:0] pe;
				logic signed [PQW-1:0] pq;
				logic signed [C_W-1:0] cpos;
				logic signed [C_W-1:0] cneg;
				logic [1:0]            nz;
				st   = pipe_s[k-1];
				cpos = '0;
				nz   = '0;
				for (int i = 0; i < 3; i++) begin
					pe   = PQW'($signed(st.p[i]));
					pq   = (pe <<< DOT_SHL) >>> DOT_SHR;
					cpos = cpos + C_W'(pq);
					nz   = nz + 2'((st.p[i] & DOT_MASK) != '0);
				end
				cneg = -cpos - $signed(C_W'(nz));
				st.leave = (cpos > 0);
				if (st.leave) begin
					st.c = cneg;
					for (int i = 0; i < 3; i++) begin
						st.nv[i] = -st.nv[i];
					end
				end else begin
					st.c = cpos;
				end
				// 2^36 + r/2 split: high part 2^9, low 27 bits r/2
				st.eta_div.rem = ETA_REM_INIT;
				st.eta_div.lo  = ETA_W'(st.r >> 1);
				st.eta_div.q   = '0;
			end
		end else if (k >= ST_ETA0 && k < ST_E1) begin : g_eta
			localparam int unsigned E = k - ST_ETA0;
			always_comb begin
				st = pipe_s[k-1];
				for (int j = 0; j < ETA_STEPS; j++) begin
					if (E * ETA_STEPS + j < ETA_ITERS) begin
						st.eta_div = eta_step(st.eta_div, st.r);
					end
				end
			end
		end else if (k == ST_E1) begin : g_e1
			// pick eta, then squares and eta*c
			always_comb begin
				logic signed [2*C_W-1:0]    cc;
				logic [2*ETA_W-1:0]         ee;
				logic signed [ETA_W+C_W:0]  ec;
				st     = pipe_s[k-1];
				st.eta = st.leave ? {st.r, 12'd0} : st.eta_div.q;
				cc     = $signed(st.c) * $signed(st.c);
				ee     = st.eta * st.eta;
				ec     = $signed({1'b0, st.eta}) * $signed(st.c);
				st.c2   = cc[IQ_FRAC +: C2_W];
				st.eta2 = ee[IQ_FRAC +: ETA2_W];
				st.etac = ec[IQ_FRAC +: ETAC_W];
			end
		end else if (k == ST_E2) begin : g_e2
			// sin^2 of the transmitted angle
			always_comb begin
				logic signed [33:0] omc;
				logic signed [65:0] sp;
				st   = pipe_s[k-1];
				omc  = ONE_OMC - $signed({1'b0, st.c2});
				sp   = $signed({1'b0, st.eta2}) * omc;
				st.s = sp[IQ_FRAC +: S_W];
			end
		end else if (k == ST_E3) begin : g_e3
			// flag total internal reflection, load the cosT radicand
			always_comb begin
				logic signed [S_W-1:0] oms;
				st        = pipe_s[k-1];
				st.tir    = ($signed(st.s) > ONE_S);
				oms       = ONE_S - $signed(st.s);
				st.sq.rem  = '0;
				st.sq.root = '0;
				st.sq.x    = st.tir ? '0 : SQ_IN_W'({oms[S_W-2:0], 24'd0});
			end
		end else if ((k >= ST_Q1 && k < ST_F1) || (k >= ST_Q2 && k < ST_N0)) begin : g_sqrt
			always_comb begin
				st = pipe_s[k-1];
				for (int j = 0; j < SQ_STEPS; j++) begin
					st.sq = sqrt_step(st.sq);
				end
			end
		end else if (k == ST_F1) begin : g_f1
			always_comb begin
				st      = pipe_s[k-1];
				st.coef = COEF_W'($signed(st.etac)) + $signed({2'b00, st.sq.root});
			end
		end else if (k == ST_F2) begin : g_f2
			// eta*D and coef*N per axis
			always_comb begin
				logic signed [DQE-1:0]          de;
				logic signed [DQE-1:0]          ne;
				logic signed [Q_W-1:0]          dq;
				logic signed [Q_W-1:0]          nq;
				logic signed [ETA_W+Q_W:0]      edp;
				logic signed [COEF_W+Q_W-1:0]   cnp;
				st = pipe_s[k-1];
				for (int i = 0; i < 3; i++) begin
					de       = DQE'($signed(st.dv[i]));
					ne       = DQE'($signed(st.nv[i]));
					dq       = Q_W'((de <<< DQ_SHL) >>> DQ_SHR);
					nq       = Q_W'((ne <<< DQ_SHL) >>> DQ_SHR);
					edp      = $signed({1'b0, st.eta}) * dq;
					cnp      = $signed(st.coef) * nq;
					st.ed[i] = edp[IQ_FRAC +: ED_W];
					st.cn[i] = cnp[IQ_FRAC +: CN_W];
				end
			end
		end else if (k == ST_F3) begin : g_f3
			// transmitted vector, clamped to +-64
			always_comb begin
				logic signed [TD_W-1:0] td;
				st = pipe_s[k-1];
				for (int i = 0; i < 3; i++) begin
					td = TD_W'($signed(st.ed[i])) - TD_W'($signed(st.cn[i]));
					if (td > T_MAX) begin
						st.t[i] = T_W'(T_MAX);
					end else if (td < T_MIN) begin
						st.t[i] = T_W'(T_MIN);
					end else begin
						st.t[i] = T_W'(td);
					end
				end
			end
		end else if (k == ST_F4) begin : g_f4
			always_comb begin
				logic signed [2*T_W-1:0] tt;
				st = pipe_s[k-1];
				for (int i = 0; i < 3; i++) begin
					tt        = $signed(st.t[i]) * $signed(st.t[i]);
					st.tsq[i] = tt[TSQ_W-1:0];
				end
			end
		end else if (k == ST_F5) begin : g_f5
			// squared length, load the second root
			always_comb begin
				st         = pipe_s[k-1];
				st.sq.rem  = '0;
				st.sq.root = '0;
				st.sq.x    = SQ_IN_W'(st.tsq[0]) + SQ_IN_W'(st.tsq[1]) + SQ_IN_W'(st.tsq[2]);
			end
		end else if (k == ST_N0) begin : g_n0
			// (|t| << F) + len/2 split into a partial remainder below len
			always_comb begin
				logic [MAG_W-1:0] mag;
				logic [NUM_W-1:0] num;
				st     = pipe_s[k-1];
				st.len = st.sq.root;
				for (int i = 0; i < 3; i++) begin
					st.neg[i] = st.t[i][T_W-1];
					mag = st.neg[i] ? MAG_W'(-$signed(st.t[i])) : MAG_W'(st.t[i]);
					num = (NUM_W'(mag) << F) + NUM_W'(st.len >> 1);
					st.nd[i].rem = NRM_REM_W'(num >> (F + 1));
					st.nd[i].lo  = LEN_W'(num[F:0]) << (LEN_W - 1 - F);
					st.nd[i].q   = '0;
				end
			end
		end else if (k >= ST_N1 && k < ST_G1) begin : g_nrm
			localparam int unsigned E = k - ST_N1;
			always_comb begin
				st = pipe_s[k-1];
				for (int j = 0; j < NRM_STEPS; j++) begin
					if (E * NRM_STEPS + j < NRM_ITERS) begin
						for (int i = 0; i < 3; i++) begin
							st.nd[i] = nrm_step(st.nd[i], st.len);
						end
					end
				end
			end
		end else if (k == ST_G1) begin : g_g1
			// signed direction (never above 1.0), then offset * dir
			always_comb begin
				logic [F:0] qv;
				st = pipe_s[k-1];
				for (int i = 0; i < 3; i++) begin
					qv = st.nd[i].q[F:0];
					if (st.len == '0) begin
						st.dir[i] = '0;
					end else if (st.neg[i]) begin
						st.dir[i] = -DIR_WIDTH'(qv);
					end else begin
						st.dir[i] = DIR_WIDTH'(qv);
					end
					st.prod[i] = PROD_W'($signed({1'b0, surface_offset_q})
						* $signed(st.dir[i]));
				end
			end
		end else begin : g_g2
			// round half up back to Q16.16
			always_comb begin
				logic signed [PROD_W:0] rs;
				st = pipe_s[k-1];
				for (int i = 0; i < 3; i++) begin
					rs        = (PROD_W + 1)'($signed(st.prod[i])) + RND;
					st.off[i] = rs[F +: OFF_W];
				end
			end
		end

		assign nxt[k] = st;
	end

	// valid bits: advance one stage per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= ST_LAST; k++) begin
				vld_s[k] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			vld_s[1] <= accept;
			for (int k = 2; k <= ST_LAST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			done_q <= vld_s[ST_LAST];
		end
	end

	// data registers: load every cycle, the valid bit says what they mean
	always_ff @(posedge clk) begin
		for (int k = 1; k <= ST_LAST; k++) begin
			pipe_s[k] <= nxt[k];
		end
	end

	// result register: add the offset, saturate, zero out on reflection
	always_ff @(posedge clk) begin
		logic signed [SUM_W-1:0] sum;
		if (vld_s[ST_LAST]) begin
			refracted_q <= ~pipe_s[ST_LAST].tir;
			for (int i = 0; i < 3; i++) begin
				sum = SUM_W'($signed(pipe_s[ST_LAST].hit[i]))
					+ SUM_W'($signed(pipe_s[ST_LAST].off[i]));
				if (pipe_s[ST_LAST].tir) begin
					origin_q[i] <= '0;
					dir_q[i]    <= '0;
				end else begin
					if (sum > HIT_MAX) begin
						origin_q[i] <= HIT_W'(HIT_MAX);
					end else if (sum < HIT_MIN) begin
						origin_q[i] <= HIT_W'(HIT_MIN);
					end else begin
						origin_q[i] <= HIT_W'(sum);
					end
					dir_q[i] <= pipe_s[ST_LAST].dir[i];
				end
			end
		end
	end

	assign done      = done_q;
	assign refracted = refracted_q;
	assign origin_x  = origin_q[0];
	assign origin_y  = origin_q[1];
	assign origin_z  = origin_q[2];
	assign out_dir_x = dir_q[0];
	assign out_dir_y = dir_q[1];
	assign out_dir_z = dir_q[2];

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Refracted ray generate unit testbench
// Streams hit transactions through the unit in bursts and compares every
// result, field by field, against a fixed-point predictor of the refraction
// kept in step with the surface offset register across several settings.
// ----------------------------------------------------------------------------
module tb_top;

	import rrg_pkg::*;

	localparam int unsigned DW      = DIR_WIDTH_DEF;
	localparam int unsigned DF      = DW - 2;
	localparam longint      ONE_Q   = 64'sd1 <<< IQ_FRAC;
	localparam longint      T_CLAMP = 64'sd1 <<< 30;
	localparam int          LATENCY = 50 + (DW / 2);
	localparam longint      CYCLE_LIMIT = 400000;

	// one incoming transaction
	typedef struct packed {
		logic signed [HIT_W-1:0] hx, hy, hz;
		logic signed [DW-1:0]    nx, ny, nz;
		logic signed [DW-1:0]    ix, iy, iz;
		logic [INDEX_W-1:0]      idx;
	} ray_hit_t;

	// one result as the unit shows it
	typedef struct packed {
		logic                    refr;
		logic signed [HIT_W-1:0] ox, oy, oz;
		logic signed [DW-1:0]    dx, dy, dz;
	} ray_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic cfg_wr_en = 1'b0;
	logic [OFFSET_W-1:0] cfg_wr_data = '0;
	logic signed [HIT_W-1:0] hit_x = '0, hit_y = '0, hit_z = '0;
	logic signed [DW-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic signed [DW-1:0] incoming_x = '0, incoming_y = '0, incoming_z = '0;
	logic [INDEX_W-1:0] refractive_index = '0;
	logic refracted;
	logic signed [HIT_W-1:0] origin_x, origin_y, origin_z;
	logic signed [DW-1:0] out_dir_x, out_dir_y, out_dir_z;

	ray_hit_t       ray_backlog[$];
	ray_out_t       rays_due[$];
	logic [OFFSET_W-1:0] offset_shadow = OFFSET_RESET;
	int             queued_n = 0;
	int             taken_n = 0;
	int             error_n = 0;
	longint         cycle_n = 0;

	refracted_ray_generate_unit #(.DIR_WIDTH(DW)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.incoming_x(incoming_x), .incoming_y(incoming_y), .incoming_z(incoming_z),
		.refractive_index(refractive_index), .refracted(refracted),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > x)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (x >= res + bit_w) begin
				x = x - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	// each product is floored to 24 fraction bits before the sum
	function automatic longint cos_dot(longint a0, longint a1, longint a2,
	                                   longint b0, longint b1, longint b2);
		return ((a0 * b0) >>> (2 * DF - IQ_FRAC)) + ((a1 * b1) >>> (2 * DF - IQ_FRAC))
		     + ((a2 * b2) >>> (2 * DF - IQ_FRAC));
	endfunction

	function automatic ray_out_t refract_predict(ray_hit_t h, logic [OFFSET_W-1:0] ofs);
		longint nv[3], dv[3], hv[3], tv[3], dir[3];
		longint c, eta, c2, eta2, s, coef, t, d, o, ofs_l, dhi, dlo;
		longint unsigned r, ct, len2, len, mag, q;
		ray_out_t res;
		hv[0] = h.hx; hv[1] = h.hy; hv[2] = h.hz;
		nv[0] = h.nx; nv[1] = h.ny; nv[2] = h.nz;
		dv[0] = h.ix; dv[1] = h.iy; dv[2] = h.iz;
		r = h.idx;
		ofs_l = ofs;
		dhi = (64'sd1 <<< (DW - 1)) - 1;
		dlo = -dhi - 1;
		if (r < MIN_INDEX)
			r = MIN_INDEX;
		c = cos_dot(nv[0], nv[1], nv[2], dv[0], dv[1], dv[2]);
		if (c > 0) begin
			// leaving the material: flip the normal, eta is the index itself
			for (int i = 0; i < 3; i++)
				nv[i] = -nv[i];
			c = cos_dot(nv[0], nv[1], nv[2], dv[0], dv[1], dv[2]);
			eta = longint'(r << 12);
		end else begin
			eta = longint'(((64'd1 << 36) + r / 2) / r);
		end
		c2 = (c * c) >>> IQ_FRAC;
		eta2 = (eta * eta) >>> IQ_FRAC;
		s = (eta2 * (ONE_Q - c2)) >>> IQ_FRAC;
		res = '0;
		if (s > ONE_Q)
			return res;
		ct = int_sqrt(longint'(ONE_Q - s) * longint'(ONE_Q));
		coef = ((eta * c) >>> IQ_FRAC) + longint'(ct);
		len2 = 0;
		for (int i = 0; i < 3; i++) begin
			t = ((eta * (dv[i] <<< (IQ_FRAC - DF))) >>> IQ_FRAC)
			  - ((coef * (nv[i] <<< (IQ_FRAC - DF))) >>> IQ_FRAC);
			if (t > T_CLAMP) t = T_CLAMP;
			if (t < -T_CLAMP) t = -T_CLAMP;
			tv[i] = t;
			len2 = len2 + longint'(t * t);
		end
		len = int_sqrt(len2);
		res.refr = 1'b1;
		for (int i = 0; i < 3; i++) begin
			d = 0;
			if (len != 0) begin
				mag = (tv[i] < 0) ? -tv[i] : tv[i];
				q = ((mag << DF) + len / 2) / len;
				d = (tv[i] < 0) ? -longint'(q) : longint'(q);
				if (d > dhi) d = dhi;
				if (d < dlo) d = dlo;
			end
			dir[i] = d;
			o = hv[i] + ((ofs_l * d + (64'sd1 <<< (DF - 1))) >>> DF);
			if (o > 64'sd2147483647) o = 64'sd2147483647;
			if (o < -64'sd2147483648) o = -64'sd2147483648;
			hv[i] = o;
		end
		res.ox = HIT_W'(hv[0]); res.oy = HIT_W'(hv[1]); res.oz = HIT_W'(hv[2]);
		res.dx = DW'(dir[0]); res.dy = DW'(dir[1]); res.dz = DW'(dir[2]);
		return res;
	endfunction

	// -------------------------------------------------------------------- driver

	ray_hit_t cur_ray;
	int       burst_left = 0;
	int       gap_left = 0;

	always @(posedge clk) begin : drive_rays
		logic next_start;
		next_start = 1'b0;
		if (arst_n) begin
			// the transaction on the ports is taken at this edge
			if (start && !busy) begin
				rays_due.push_back(refract_predict(cur_ray, offset_shadow));
				taken_n++;
			end
			if (start && busy) begin
				next_start = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (ray_backlog.size() > 0) begin
				cur_ray = ray_backlog.pop_front();
				hit_x <= cur_ray.hx; hit_y <= cur_ray.hy; hit_z <= cur_ray.hz;
				normal_x <= cur_ray.nx; normal_y <= cur_ray.ny; normal_z <= cur_ray.nz;
				incoming_x <= cur_ray.ix; incoming_y <= cur_ray.iy;
				incoming_z <= cur_ray.iz;
				refractive_index <= cur_ray.idx;
				next_start = 1'b1;
				// close the burst and pick the gap that follows it
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end
			start <= next_start;
		end
	end

	// ------------------------------------------------------------------- monitor

	task automatic flag_mismatch(string what, longint got, longint want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		error_n++;
	endtask

	always @(posedge clk) begin : watch_results
		ray_out_t want;
		if (arst_n && done) begin
			if (rays_due.size() == 0) begin
				flag_mismatch("unexpected result", 1, 0);
			end else begin
				want = rays_due.pop_front();
				if (refracted !== want.refr) flag_mismatch("refracted", refracted, want.refr);
				if (origin_x !== want.ox) flag_mismatch("origin_x", origin_x, want.ox);
				if (origin_y !== want.oy) flag_mismatch("origin_y", origin_y, want.oy);
				if (origin_z !== want.oz) flag_mismatch("origin_z", origin_z, want.oz);
				if (out_dir_x !== want.dx) flag_mismatch("out_dir_x", out_dir_x, want.dx);
				if (out_dir_y !== want.dy) flag_mismatch("out_dir_y", out_dir_y, want.dy);
				if (out_dir_z !== want.dz) flag_mismatch("out_dir_z", out_dir_z, want.dz);
			end
		end
	end

	// hard stop should the unit stall or lose results
	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ----------------------------------------------------------------- stimulus

	task automatic queue_ray(longint hx, longint hy, longint hz, longint nx, longint ny,
	                         longint nz, longint ix, longint iy, longint iz, longint idx);
		ray_hit_t h;
		h.hx = HIT_W'(hx); h.hy = HIT_W'(hy); h.hz = HIT_W'(hz);
		h.nx = DW'(nx); h.ny = DW'(ny); h.nz = DW'(nz);
		h.ix = DW'(ix); h.iy = DW'(iy); h.iz = DW'(iz);
		h.idx = INDEX_W'(idx);
		ray_backlog.push_back(h);
		queued_n++;
	endtask

	// random direction of unit length in Q2.14
	task automatic unit_dir(output longint x, output longint y, output longint z);
		real a, b, c, m;
		m = 0.0;
		while (m < 1.0) begin
			a = $itor($urandom_range(0, 2000)) - 1000.0;
			b = $itor($urandom_range(0, 2000)) - 1000.0;
			c = $itor($urandom_range(0, 2000)) - 1000.0;
			m = $sqrt(a * a + b * b + c * c);
		end
		x = $rtoi(a * 16384.0 / m);
		y = $rtoi(b * 16384.0 / m);
		z = $rtoi(c * 16384.0 / m);
	endtask

	task automatic queue_random(int n);
		longint nx, ny, nz, ix, iy, iz, idx;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				// noise: every field raw
				queue_ray(longint'(int'($urandom)), longint'(int'($urandom)),
				          longint'(int'($urandom)), longint'(shortint'($urandom)),
				          longint'(shortint'($urandom)), longint'(shortint'($urandom)),
				          longint'(shortint'($urandom)), longint'(shortint'($urandom)),
				          longint'(shortint'($urandom)), $urandom_range(0, 32767));
			end else begin
				unit_dir(nx, ny, nz);
				unit_dir(ix, iy, iz);
				// mostly glass-like indices, now and then anything in range
				idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
				                                  : $urandom_range(4096, 12288);
				queue_ray(longint'(int'($urandom)) >>> $urandom_range(0, 16),
				          longint'(int'($urandom)) >>> $urandom_range(0, 16),
				          longint'(int'($urandom)), nx, ny, nz, ix, iy, iz, idx);
			end
		end
	endtask

	task automatic write_offset(logic [OFFSET_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		offset_shadow = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// hold the sender until every transaction queued so far has come back
	task automatic drain;
		while (taken_n != queued_n || rays_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset offset in force
		queue_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 4096);                  // zero-length T
		queue_ray(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 6144);          // grazing ray
		queue_ray(0, 0, 0, 0, 0, 16384, 0, 0, -16384, 6144);         // straight in
		queue_ray(0, 0, 0, 0, 0, 16384, 0, 0, 16384, 6144);          // straight out
		queue_ray(0, 0, 0, 0, 0, 16384, 0, 13000, 9970, 6144);       // internal reflection
		queue_ray(0, 0, 0, 0, 0, 16384, 0, 9000, -13690, 0);         // index below range
		queue_ray(0, 0, 0, 0, 0, 16384, 0, 9000, -13690, 1023);
		queue_ray(0, 0, 0, 0, 0, 16384, 0, 9000, -13690, 1024);
		queue_ray(0, 0, 0, 0, 0, 16384, 0, 9000, -13690, 32767);
		queue_ray(0, 0, 0, 0, 0, 16384, 0, 9000, 13690, 32767);
		queue_ray(2147483647, 2147483647, 2147483647, 0, 0, -16384, 9000, 9000, 9000, 4096);
		queue_ray(-2147483648, -2147483648, -2147483648, 0, 0, 16384, -9000, -9000, -9000,
		          4096);
		queue_ray(0, 0, 0, 32767, 32767, 32767, -32768, -32768, -32768, 4096);
		queue_ray(0, 0, 0, -32768, -32768, -32768, -32768, -32768, -32768, 32767);
		queue_ray(0, 0, 0, 32767, -32768, 32767, 32767, 32767, -32768, 1024);
		queue_random(400);
		drain();

		// largest offset: drive the origins into saturation
		write_offset(16'hFFFF);
		queue_ray(2147483647, 2147483647, 2147483647, 0, 0, -16384, 9000, 9000, 9000, 4096);
		queue_ray(-2147483648, -2147483648, -2147483648, 0, 0, 16384, -9000, -9000, -9000,
		          4096);
		queue_random(350);
		drain();

		write_offset(16'h0000);
		queue_random(350);
		drain();

		write_offset(16'($urandom));
		queue_random(350);
		drain();

		// allow the pipeline to settle before the verdict
		repeat (LATENCY + 20) @(posedge clk);
		if (error_n == 0 && rays_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/rrg_pkg.sv
rtl/refracted_ray_generate_unit.sv
verif/tb_top.sv
